>>> rtl/fcft_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcft_pkg: shared types and constants for the fan curve unit
// Word formats, state encodings, register indexes and reset values.
// ----------------------------------------------------------------------------
package fcft_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CPU_LOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPU_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NVME_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NVME_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING   = 3'd5;

  localparam logic [10:0] RST_CPU_LOW   = 11'd400;
  localparam logic [10:0] RST_CPU_HIGH  = 11'd600;
  localparam logic [10:0] RST_NVME_LOW  = 11'd400;
  localparam logic [10:0] RST_NVME_HIGH = 11'd650;
  localparam logic [7:0]  RST_FLOOR     = 8'd30;
  localparam logic [7:0]  RST_CEILING   = 8'd255;

  typedef struct packed {
    logic [1:0]         device;
    logic signed [11:0] cpu_temp;
    logic signed [11:0] nvme_temp;
  } in_word_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       duty_changed;
    logic       no_data;
  } out_word_t;

  typedef struct packed {
    logic signed [11:0] t;
    logic [10:0]        low;
    logic [10:0]        high;
    logic [7:0]         floor;
    logic [7:0]         ceiling;
  } curve_req_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] duty;
  } curve_sts_t;

  typedef enum logic [1:0] {
    TOP_IDLE,
    TOP_SCAN,
    TOP_START,
    TOP_WAIT
  } top_state_t;

  typedef enum logic [2:0] {
    CRV_IDLE,
    CRV_DIV,
    CRV_SQ,
    CRV_SQRT,
    CRV_PMUL,
    CRV_MAG,
    CRV_FINISH
  } curve_state_t;

endpackage
`default_nettype wire

>>> rtl/fcft_curve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcft_curve: serial power-curve evaluator
// duty = floor + r^2.5 * (ceiling - floor), r = (t - low) / (high - low) in
// Q0.16. Radix-2 divide, radix-2 square root and three shift-add multiplies,
// 16 steps each, on one narrow datapath.
// ----------------------------------------------------------------------------
module fcft_curve (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  fcft_pkg::curve_req_t req,
  output fcft_pkg::curve_sts_t sts
);
  import fcft_pkg::*;

  curve_state_t state_r, state_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [17:0]  rem_r, rem_nxt;
  logic [15:0]  root_r, root_nxt;
  logic [15:0]  xsh_r, xsh_nxt;
  logic [15:0]  mcand_r, mcand_nxt;
  logic [31:0]  prod_r, prod_nxt;
  logic [7:0]   duty_r, duty_nxt;

  logic signed [11:0] low_s, high_s;
  logic [11:0]        dist_full;
  logic [10:0]        span;
  logic               at_floor, at_ceiling, rising, last;
  logic [11:0]        div_sh;
  logic               div_ge;
  logic [17:0]        sq_sh, sq_trial;
  logic               sq_ge;
  logic [16:0]        mul_sum;
  logic [7:0]         diff, mag;

  assign low_s      = $signed({1'b0, req.low});
  assign high_s     = $signed({1'b0, req.high});
  assign at_floor   = (req.t <= low_s);
  assign at_ceiling = (req.t >= high_s);
  assign dist_full  = req.t - low_s;
  assign span       = req.high - req.low;
  assign rising     = (req.ceiling >= req.floor);
  assign diff       = rising ? (req.ceiling - req.floor) : (req.floor - req.ceiling);
  assign last       = (cnt_r == 4'd15);

  assign div_sh   = {rem_r[10:0], 1'b0};
  assign div_ge   = (div_sh >= {1'b0, span});
  assign sq_sh    = {rem_r[15:0], xsh_r[15:14]};
  assign sq_trial = {root_r, 2'b01};
  assign sq_ge    = (sq_sh >= sq_trial);
  assign mul_sum  = {1'b0, prod_r[31:16]} + (prod_r[0] ? {1'b0, mcand_r} : 17'd0);
  assign mag      = mul_sum[8:1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CRV_IDLE: begin
        if (start) begin
          state_nxt = (at_floor || at_ceiling) ? CRV_FINISH : CRV_DIV;
        end
      end
      CRV_DIV:    if (last) state_nxt = CRV_SQ;
      CRV_SQ:     if (last) state_nxt = CRV_SQRT;
      CRV_SQRT:   if (last) state_nxt = CRV_PMUL;
      CRV_PMUL:   if (last) state_nxt = CRV_MAG;
      CRV_MAG:    if (last) state_nxt = CRV_FINISH;
      CRV_FINISH: state_nxt = CRV_IDLE;
      default:    state_nxt = CRV_IDLE;
    endcase
  end

  always_comb begin
    sts.busy = (state_r != CRV_IDLE);
    sts.duty = duty_r;
  end

  always_comb begin
    cnt_nxt   = 4'd0;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    xsh_nxt   = xsh_r;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    duty_nxt  = duty_r;
    case (state_r)
      CRV_IDLE: begin
        if (start) begin
          duty_nxt = at_floor ? req.floor : req.ceiling;
          rem_nxt  = {7'd0, dist_full[10:0]};
          root_nxt = 16'd0;
        end
      end
      CRV_DIV: begin
        cnt_nxt  = cnt_r + 4'd1;
        rem_nxt  = div_ge ? {6'd0, div_sh - {1'b0, span}} : {6'd0, div_sh};
        root_nxt = {root_r[14:0], div_ge};
        if (last) begin
          prod_nxt  = {16'd0, root_r[14:0], div_ge};
          mcand_nxt = {root_r[14:0], div_ge};
          xsh_nxt   = {root_r[14:0], div_ge};
          rem_nxt   = 18'd0;
          root_nxt  = 16'd0;
        end
      end
      CRV_SQ: begin
        cnt_nxt  = cnt_r + 4'd1;
        prod_nxt = {mul_sum, prod_r[15:1]};
        if (last) begin
          mcand_nxt = mul_sum[16:1];
        end
      end
      CRV_SQRT: begin
        cnt_nxt  = cnt_r + 4'd1;
        rem_nxt  = sq_ge ? (sq_sh - sq_trial) : sq_sh;
        root_nxt = {root_r[14:0], sq_ge};
        xsh_nxt  = {xsh_r[13:0], 2'b00};
        if (last) begin
          prod_nxt = {16'd0, root_r[14:0], sq_ge};
        end
      end
      CRV_PMUL: begin
        cnt_nxt  = cnt_r + 4'd1;
        prod_nxt = {mul_sum, prod_r[15:1]};
        if (last) begin
          prod_nxt  = {16'd0, mul_sum[16:1]};
          mcand_nxt = {8'd0, diff};
        end
      end
      CRV_MAG: begin
        cnt_nxt  = cnt_r + 4'd1;
        prod_nxt = {mul_sum, prod_r[15:1]};
        if (last) begin
          duty_nxt = rising ? (req.floor + mag) : (req.floor - mag);
        end
      end
      CRV_FINISH: begin
        cnt_nxt = 4'd0;
      end
      default: begin
        cnt_nxt = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CRV_IDLE;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    root_r  <= root_nxt;
    xsh_r   <= xsh_nxt;
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
    duty_r  <= duty_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/fan_curve_from_temperatures_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fan_curve_from_temperatures_unit: fan duty from device temperature reports
// Stores each device's CPU/NVMe report, takes the maxima over devices with
// data and maps them through a clamped r^2.5 curve to a PWM duty.
//
// Input channel (in_valid/in_ready, in_word): one report word per item.
// in_ready is high only while the block is idle between reports.
// Output channel (out_valid/out_ready, out_word): one result word per report,
// held in an output register; the next report is taken while it waits.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
// write only while no report is in flight.
// After the accepting edge a report passes through the scan of every device
// store, a start state, the two curve units running side by side (five
// 16-step serial passes and a finish state) and the load of the output
// register. A new report is taken only once the block is idle again, after
// the previous result has been loaded into the output register.
// A curve unit given a clamped temperature finishes early. A stalled
// receiver holds the finished word and blocks the next result.
// Reset clears the stores, loads register defaults and sets duty to 30.
// ----------------------------------------------------------------------------
module fan_curve_from_temperatures_unit #(
  parameter int DEVICE_COUNT = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fcft_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fcft_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fcft_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fcft_pkg::*;

  localparam int IDX_W = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEVICE_COUNT - 1);

  top_state_t state_r, state_nxt;

  logic signed [11:0] cpu_store_r  [DEVICE_COUNT];
  logic signed [11:0] nvme_store_r [DEVICE_COUNT];

  logic [IDX_W-1:0]   scan_cnt_r, scan_cnt_nxt;
  logic signed [11:0] top_cpu_r, top_cpu_nxt;
  logic signed [11:0] top_nvme_r, top_nvme_nxt;
  logic               any_r, any_nxt;
  logic [7:0]         duty_now_r, duty_now_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic [10:0] cpu_low_r, cpu_high_r, nvme_low_r, nvme_high_r;
  logic [7:0]  floor_r, ceil_r;

  logic               in_acc, cfg_acc, dev_ok, start, finish, has_data;
  logic signed [11:0] scan_cpu, scan_nvme;
  logic [7:0]         duty_pick;
  curve_req_t         cpu_req, nvme_req;
  curve_sts_t         cpu_sts, nvme_sts;

  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign dev_ok    = ({30'd0, in_word.device} < 32'(DEVICE_COUNT));
  assign scan_cpu  = cpu_store_r[scan_cnt_r];
  assign scan_nvme = nvme_store_r[scan_cnt_r];
  assign has_data  = (scan_cpu > 12'sd0) || (scan_nvme > 12'sd0);
  assign finish    = (state_r == TOP_WAIT) && !cpu_sts.busy && !nvme_sts.busy &&
                     (!out_valid_r || out_ready);
  assign duty_pick = !any_r ? floor_r :
                     ((cpu_sts.duty > nvme_sts.duty) ? cpu_sts.duty : nvme_sts.duty);

  assign cpu_req  = '{t: top_cpu_r, low: cpu_low_r, high: cpu_high_r,
                      floor: floor_r, ceiling: ceil_r};
  assign nvme_req = '{t: top_nvme_r, low: nvme_low_r, high: nvme_high_r,
                      floor: floor_r, ceiling: ceil_r};

  fcft_curve u_cpu_curve (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (cpu_req),
    .sts   (cpu_sts)
  );

  fcft_curve u_nvme_curve (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (nvme_req),
    .sts   (nvme_sts)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      TOP_IDLE:  if (in_acc) state_nxt = TOP_SCAN;
      TOP_SCAN:  if (scan_cnt_r == LAST_IDX) state_nxt = TOP_START;
      TOP_START: state_nxt = TOP_WAIT;
      TOP_WAIT:  if (finish) state_nxt = TOP_IDLE;
      default:   state_nxt = TOP_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == TOP_IDLE);
    start     = (state_r == TOP_START);
    cfg_ready = 1'b1;
    out_valid = out_valid_r;
    out_word  = out_word_r;
  end

  always_comb begin
    scan_cnt_nxt = scan_cnt_r;
    top_cpu_nxt  = top_cpu_r;
    top_nvme_nxt = top_nvme_r;
    any_nxt      = any_r;
    if (in_acc) begin
      scan_cnt_nxt = '0;
      top_cpu_nxt  = 12'sd0;
      top_nvme_nxt = 12'sd0;
      any_nxt      = 1'b0;
    end else if (state_r == TOP_SCAN) begin
      scan_cnt_nxt = scan_cnt_r + 1'b1;
      if (has_data) begin
        any_nxt = 1'b1;
        if (scan_cpu > top_cpu_r) top_cpu_nxt = scan_cpu;
        if (scan_nvme > top_nvme_r) top_nvme_nxt = scan_nvme;
      end
    end
  end

  always_comb begin
    duty_now_nxt  = duty_now_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (finish) begin
      out_valid_nxt             = 1'b1;
      duty_now_nxt              = duty_pick;
      out_word_nxt.pwm_duty     = duty_pick;
      out_word_nxt.duty_changed = (duty_pick != duty_now_r);
      out_word_nxt.no_data      = !any_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= TOP_IDLE;
      out_valid_r <= 1'b0;
      duty_now_r  <= RST_FLOOR;
      scan_cnt_r  <= '0;
      any_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      duty_now_r  <= duty_now_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      any_r       <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_cpu_r  <= top_cpu_nxt;
    top_nvme_r <= top_nvme_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEVICE_COUNT; i++) begin
        cpu_store_r[i]  <= 12'sd0;
        nvme_store_r[i] <= 12'sd0;
      end
    end else if (in_acc && dev_ok) begin
      cpu_store_r[IDX_W'(in_word.device)]  <= in_word.cpu_temp;
      nvme_store_r[IDX_W'(in_word.device)] <= in_word.nvme_temp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_low_r   <= RST_CPU_LOW;
      cpu_high_r  <= RST_CPU_HIGH;
      nvme_low_r  <= RST_NVME_LOW;
      nvme_high_r <= RST_NVME_HIGH;
      floor_r     <= RST_FLOOR;
      ceil_r      <= RST_CEILING;
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_CPU_LOW:   cpu_low_r   <= cfg_data;
        CFG_CPU_HIGH:  cpu_high_r  <= cfg_data;
        CFG_NVME_LOW:  nvme_low_r  <= cfg_data;
        CFG_NVME_HIGH: nvme_high_r <= cfg_data;
        CFG_FLOOR:     floor_r     <= cfg_data[7:0];
        CFG_CEILING:   ceil_r      <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // curve units sit idle whenever a new report can be taken
  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TOP_IDLE) |-> (!cpu_sts.busy && !nvme_sts.busy))
    else $error("curve unit busy while accepting a report");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TOP_SCAN) |-> (scan_cnt_r <= LAST_IDX))
    else $error("scan index out of range");

  // a data-driven duty lies between floor and ceiling
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.no_data) |->
      ((out_word_r.pwm_duty >= floor_r && out_word_r.pwm_duty <= ceil_r) ||
       (out_word_r.pwm_duty <= floor_r && out_word_r.pwm_duty >= ceil_r)))
    else $error("duty outside floor/ceiling");

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: testbench for fan_curve_from_temperatures_unit
// Sends device temperature reports over the input channel and reprograms the
// curve registers between phases. A local model of the stores and the r^2.5
// curve predicts every duty word; a monitor compares each word it receives
// with the oldest prediction. Directed corners are followed by random traffic
// under several sender/receiver idling mixes, a long receiver hold-off and
// sender pauses.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fcft_pkg::*;

  localparam int N_DEV = 4;
  localparam int LAT = N_DEV + 90;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // curve settings and device stores as the block should hold them
  logic [10:0]        cpu_lo, cpu_hi, nvme_lo, nvme_hi;
  logic [7:0]         duty_floor, duty_ceil;
  logic signed [11:0] cpu_hist [N_DEV];
  logic signed [11:0] nvme_hist [N_DEV];
  logic [7:0]         duty_last;

  out_word_t duty_q[$];
  out_word_t want;
  int        fail_cnt = 0;
  int        cycles = 0;
  int        tx_idle_pct = 0;
  int        rx_stall_pct = 0;
  int        hold_req = 0;
  int        hold_cnt = 0;

  fan_curve_from_temperatures_unit #(.DEVICE_COUNT(N_DEV)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (duty_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected word: duty=%0d chg=%0b nodata=%0b",
                   out_word.pwm_duty, out_word.duty_changed, out_word.no_data);
      end else begin
        want = duty_q.pop_front();
        if (out_word.pwm_duty !== want.pwm_duty ||
            out_word.duty_changed !== want.duty_changed ||
            out_word.no_data !== want.no_data) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"mismatch: exp duty=%0d chg=%0b nodata=%0b, ",
                      "got duty=%0d chg=%0b nodata=%0b"},
                     want.pwm_duty, want.duty_changed, want.no_data,
                     out_word.pwm_duty, out_word.duty_changed, out_word.no_data);
        end
      end
    end
  end

  function automatic void model_reset();
    cpu_lo = RST_CPU_LOW;
    cpu_hi = RST_CPU_HIGH;
    nvme_lo = RST_NVME_LOW;
    nvme_hi = RST_NVME_HIGH;
    duty_floor = RST_FLOOR;
    duty_ceil = RST_CEILING;
    for (int i = 0; i < N_DEV; i++) begin
      cpu_hist[i] = '0;
      nvme_hist[i] = '0;
    end
    duty_last = RST_FLOOR;
  endfunction

  function automatic void model_write(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_CPU_LOW:   cpu_lo = data[10:0];
      CFG_CPU_HIGH:  cpu_hi = data[10:0];
      CFG_NVME_LOW:  nvme_lo = data[10:0];
      CFG_NVME_HIGH: nvme_hi = data[10:0];
      CFG_FLOOR:     duty_floor = data[7:0];
      CFG_CEILING:   duty_ceil = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, cand;
    res = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = res | (64'd1 << b);
      if (cand * cand <= x)
        res = cand;
    end
    return res;
  endfunction

  function automatic logic [7:0] curve_duty(int t, logic [10:0] lo, logic [10:0] hi);
    int lo_i, hi_i;
    longint unsigned frac, frac_sq, root, pw, mag;
    lo_i = int'(lo);
    hi_i = int'(hi);
    if (t <= lo_i)
      return duty_floor;
    if (t >= hi_i)
      return duty_ceil;
    frac = (longint'(t - lo_i) << 16) / longint'(hi_i - lo_i);
    frac_sq = (frac * frac) >> 16;
    root = root_floor(frac << 16);
    pw = (frac_sq * root) >> 16;
    if (duty_ceil >= duty_floor) begin
      mag = (pw * longint'(duty_ceil - duty_floor)) >> 16;
      return 8'(duty_floor + mag);
    end
    mag = (pw * longint'(duty_floor - duty_ceil)) >> 16;
    return 8'(duty_floor - mag);
  endfunction

  function automatic out_word_t predict_duty(in_word_t w);
    out_word_t o;
    int top_cpu, top_nvme;
    bit any;
    logic [7:0] a, b, duty;
    if (w.device < N_DEV) begin
      cpu_hist[w.device] = w.cpu_temp;
      nvme_hist[w.device] = w.nvme_temp;
    end
    top_cpu = 0;
    top_nvme = 0;
    any = 1'b0;
    for (int i = 0; i < N_DEV; i++) begin
      if (cpu_hist[i] > 0 || nvme_hist[i] > 0) begin
        any = 1'b1;
        if (cpu_hist[i] > top_cpu) top_cpu = int'(cpu_hist[i]);
        if (nvme_hist[i] > top_nvme) top_nvme = int'(nvme_hist[i]);
      end
    end
    if (any) begin
      a = curve_duty(top_cpu, cpu_lo, cpu_hi);
      b = curve_duty(top_nvme, nvme_lo, nvme_hi);
      duty = (a > b) ? a : b;
    end else begin
      duty = duty_floor;
    end
    o.pwm_duty = duty;
    o.duty_changed = (duty != duty_last);
    o.no_data = !any;
    duty_last = duty;
    return o;
  endfunction

  function automatic in_word_t temp_report(logic [1:0] dev, int cpu, int nvme);
    in_word_t w;
    w.device = dev;
    w.cpu_temp = 12'(cpu);
    w.nvme_temp = 12'(nvme);
    return w;
  endfunction

  // mostly around the current window, some negative, some raw 12-bit
  function automatic int pick_temp(logic [10:0] lo, logic [10:0] hi);
    int a, b, t;
    a = (lo < hi) ? int'(lo) : int'(hi);
    b = (lo < hi) ? int'(hi) : int'(lo);
    case ($urandom_range(9))
      0:       t = -int'($urandom_range(400));
      1:       t = int'($signed(12'($urandom)));
      2, 3:    t = $urandom_range(1500);
      default: t = a - 12 + int'($urandom_range(b - a + 24));
    endcase
    if (t > 2047) t = 2047;
    if (t < -2048) t = -2048;
    return t;
  endfunction

  task automatic send_report(input in_word_t w);
    int gap;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(20, 110) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    duty_q.push_back(predict_duty(w));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (duty_q.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    model_write(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_curve(input int clo, input int chi, input int nlo, input int nhi,
                            input int fl, input int cl);
    drain_results();
    write_reg(CFG_CPU_LOW, CFG_DATA_W'(clo));
    write_reg(CFG_CPU_HIGH, CFG_DATA_W'(chi));
    write_reg(CFG_NVME_LOW, CFG_DATA_W'(nlo));
    write_reg(CFG_NVME_HIGH, CFG_DATA_W'(nhi));
    write_reg(CFG_FLOOR, CFG_DATA_W'(fl));
    write_reg(CFG_CEILING, CFG_DATA_W'(cl));
  endtask

  task automatic load_random_curve();
    int lo[2], hi[2], tmp, fl, cl;
    for (int k = 0; k < 2; k++) begin
      lo[k] = $urandom_range(0, 1400);
      hi[k] = lo[k] + $urandom_range(1, 1500 - lo[k]);
      if ($urandom_range(7) == 0) begin
        tmp = lo[k];
        lo[k] = hi[k];
        hi[k] = tmp;
      end else if ($urandom_range(9) == 0) begin
        hi[k] = lo[k];
      end
    end
    fl = $urandom_range(0, 120);
    cl = $urandom_range(130, 255);
    if ($urandom_range(5) == 0) begin
      tmp = fl;
      fl = cl;
      cl = tmp;
    end
    // upper data bits are don't-care for the 8-bit duty registers
    if ($urandom_range(4) == 0) fl = fl | ($urandom_range(7) << 8);
    load_curve(lo[0], hi[0], lo[1], hi[1], fl, cl);
  endtask

  task automatic clear_all_devices();
    for (int d = 0; d < N_DEV; d++)
      send_report(temp_report(2'(d), -int'($urandom_range(400)),
                              -int'($urandom_range(400))));
  endtask

  task automatic send_random_reports(input int n);
    for (int i = 0; i < n; i++)
      send_report(temp_report(2'($urandom_range(3)), pick_temp(cpu_lo, cpu_hi),
                              pick_temp(nvme_lo, nvme_hi)));
  endtask

  task automatic test_reset_curve();
    send_report(temp_report(0, 0, 0));
    send_report(temp_report(0, 400, 0));
    send_report(temp_report(1, 500, 0));
    send_report(temp_report(2, 0, 1500));
    send_report(temp_report(2, 0, -400));
    send_report(temp_report(3, -2048, 2047));
    send_report(temp_report(3, 2047, -2048));
    send_report(temp_report(1, 599, 649));
    send_report(temp_report(1, 401, 401));
    send_report(temp_report(0, -1, -1));
    send_report(temp_report(1, 0, 0));
    send_report(temp_report(3, 0, -400));
    send_report(temp_report(2, 1, 0));
  endtask

  task automatic test_config_extremes();
    clear_all_devices();
    load_curve(0, 1500, 0, 1500, 0, 255);
    send_report(temp_report(0, 1, 1));
    send_report(temp_report(0, 750, 0));
    send_report(temp_report(0, 1499, 0));
    send_report(temp_report(0, 1500, 0));
    // misordered thresholds: anything above low is full scale
    load_curve(800, 800, 900, 300, 10, 200);
    send_report(temp_report(0, 0, 0));
    send_report(temp_report(1, 801, 0));
    send_report(temp_report(1, 0, 901));
    send_report(temp_report(1, 0, 900));
    // floor above ceiling, then floor equal to ceiling
    load_curve(400, 600, 400, 650, 200, 20);
    send_report(temp_report(1, 500, 0));
    send_report(temp_report(1, 550, 600));
    load_curve(400, 600, 400, 650, 77, 77);
    send_report(temp_report(1, 500, 0));
    load_curve(0, 2047, 0, 2047, 11'h7E5, 11'h7FF);
    write_reg(CFG_SPARE, 11'h5A5);
    send_report(temp_report(2, 2047, 2047));
    send_report(temp_report(2, 1023, -5));
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n);
    int sent, next_cfg;
    drain_results();
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    next_cfg = 0;
    while (sent < n) begin
      if (sent >= next_cfg) begin
        drain_results();
        load_random_curve();
        next_cfg += 60;
      end
      if ($urandom_range(19) == 0) begin
        clear_all_devices();
        sent += N_DEV;
      end else begin
        send_random_reports(1);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 180);
    run_random_phase(58, 0, 180);
    run_random_phase(0, 58, 180);
    run_random_phase(13, 13, 180);
  endtask

  // receiver blocks long enough for the block to fill and stop taking reports
  task automatic test_receiver_holdoff();
    drain_results();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1500;
    send_random_reports(12);
  endtask

  task automatic test_sender_pause();
    tx_idle_pct = 13;
    rx_stall_pct = 13;
    for (int r = 0; r < 3; r++) begin
      send_random_reports(8);
      drain_results();
    end
  endtask

  initial begin
    model_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_curve();
    test_config_extremes();
    test_random_traffic();
    test_receiver_holdoff();
    test_sender_pause();
    drain_results();
    repeat (LAT) @(posedge clk);
    if (fail_cnt == 0 && duty_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
